// ===== design/vqde_pkg.sv =====
// Shared types and codes for the virtqueue descriptor engine.
package vqde_pkg;

	typedef enum logic [2:0] {
		OP_WDESC  = 3'd0,
		OP_WAVAIL = 3'd1,
		OP_PUB    = 3'd2,
		OP_FETCH  = 3'd3,
		OP_RET    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_BUF  = 3'd0,
		ST_NONE = 3'd1,
		ST_RAW  = 3'd2,
		ST_LONG = 3'd3,
		ST_DONE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		C_WDESC,
		C_WAVAIL,
		C_PUB,
		C_FETCH,
		C_RET,
		C_NONE
	} cmd_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_EMIT,
		S_ERR
	} bstate_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic        queue;
		logic [5:0]  slot;
		logic [63:0] buf_addr;
		logic [31:0] buf_len;
		logic        writable;
		logic        has_next;
		logic [15:0] next_index;
		logic [15:0] head_id;
		logic [15:0] avail_index;
		logic [31:0] used_len;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] head_out;
		logic [63:0] addr_out;
		logic [31:0] len_out;
		logic        writable_out;
		logic [5:0]  position;
		logic [6:0]  readable_count;
		logic [6:0]  total_count;
		logic [15:0] used_index_out;
		logic        last;
	} out_word_t;

	typedef struct packed {
		cmd_kind_t kind;
		in_word_t  w;
	} cmd_t;

	typedef struct packed {
		logic [63:0] addr;
		logic [31:0] len;
		logic        wr;
		logic        nxt;
		logic [15:0] next;
	} desc_t;

endpackage

// ===== design/vqde_fifo.sv =====
// Small first-in first-out queue built from registers.
module vqde_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end
endmodule

// ===== design/vqde_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
module vqde_front import vqde_pkg::*; #(
	parameter int QUEUES = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t in_word,
	output logic     full,
	input  logic     cmd_pop,
	output cmd_t     cmd,
	output logic     cmd_empty
);
	cmd_t cmd_in;
	logic keep;
	logic absent;

	assign absent = (int'(in_word.queue) >= QUEUES);

	always_comb begin
		cmd_in.w    = in_word;
		cmd_in.kind = C_NONE;
		keep        = 1'b0;
		unique case (in_word.opcode)
			OP_WDESC: begin
				cmd_in.kind = C_WDESC;
				keep        = !absent;
			end
			OP_WAVAIL: begin
				cmd_in.kind = C_WAVAIL;
				keep        = !absent;
			end
			OP_PUB: begin
				cmd_in.kind = C_PUB;
				keep        = !absent;
			end
			OP_FETCH: begin
				cmd_in.kind = absent ? C_NONE : C_FETCH;
				keep        = 1'b1;
			end
			OP_RET: begin
				cmd_in.kind = C_RET;
				keep        = !absent;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	vqde_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && keep),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);
endmodule

// ===== design/vqde_back.sv =====
// Back end: ring memories, chain walker and result generation.
module vqde_back import vqde_pkg::*; #(
	parameter int RING_SIZE = 64,
	parameter int QUEUES    = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] ring_size_log2,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	input  logic       res_full,
	output logic       res_push,
	output out_word_t  res_word
);
	localparam int RLOG  = $clog2(RING_SIZE);
	localparam int CW    = RLOG + 1;
	localparam int QUSED = (QUEUES > 1) ? 2 : 1;
	localparam int AW    = $clog2(QUSED * RING_SIZE);
	localparam int DEPTH = QUSED * RING_SIZE;

	desc_t       desc_mem [DEPTH];
	logic [15:0] avail_mem [DEPTH];
	logic [47:0] used_mem [DEPTH];

	logic [15:0] avail_idx_q [2];
	logic [15:0] last_seen_q [2];
	logic [15:0] used_idx_q [2];

	bstate_t       state_q, state_d;
	logic          q_q;
	logic [15:0]   head_q;
	logic [CW-1:0] total_q, readable_q;
	logic [RLOG-1:0] pos_q;
	logic          seen_wr_q;
	status_t       err_q;
	desc_t         desc_rd_q;
	logic [15:0]   avail_rd_q;

	logic [2:0]      lg;
	logic [RLOG-1:0] mask;
	logic [CW-1:0]   n_c;
	logic            desc_re, avail_re;
	logic [AW-1:0]   desc_raddr, avail_raddr;
	logic            walk_raw, walk_long, emit_last;
	logic [RLOG-1:0] nxt_idx;
	logic            fetch_pending;
	logic            cq;

	always_comb begin
		lg = (ring_size_log2 == 3'd0) ? 3'd1 : ring_size_log2;
		if (int'(lg) > RLOG) begin
			lg = 3'(RLOG);
		end
		mask = RLOG'((32'd1 << lg) - 32'd1);
	end

	assign n_c           = {1'b0, mask} + CW'(1);
	assign cq            = cmd.w.queue;
	assign nxt_idx       = desc_rd_q.next[RLOG-1:0] & mask;
	assign walk_raw      = !desc_rd_q.wr && seen_wr_q;
	assign walk_long     = desc_rd_q.nxt && (total_q >= n_c);
	assign emit_last     = ({1'b0, pos_q} + CW'(1)) == total_q;
	assign fetch_pending = (last_seen_q[cq] != avail_idx_q[cq]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty && cmd.kind == C_FETCH && fetch_pending) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: state_d = S_WALK;
			S_WALK: begin
				if (walk_raw || walk_long) begin
					state_d = S_ERR;
				end else if (!desc_rd_q.nxt) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!res_full && emit_last) begin
					state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (!res_full) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res_word    = '0;
		res_word.last = 1'b1;
		desc_re     = 1'b0;
		avail_re    = 1'b0;
		desc_raddr  = '0;
		avail_raddr = AW'({cq, last_seen_q[cq][RLOG-1:0] & mask});
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.kind)
						C_WDESC, C_WAVAIL, C_PUB: cmd_pop = 1'b1;
						C_RET: begin
							cmd_pop  = !res_full;
							res_push = !res_full;
							res_word.status         = ST_DONE;
							res_word.head_out       = cmd.w.head_id;
							res_word.used_index_out = used_idx_q[cq] + 16'd1;
						end
						C_NONE: begin
							cmd_pop  = !res_full;
							res_push = !res_full;
							res_word.status = ST_NONE;
						end
						C_FETCH: begin
							if (fetch_pending) begin
								cmd_pop  = 1'b1;
								avail_re = 1'b1;
							end else begin
								cmd_pop  = !res_full;
								res_push = !res_full;
								res_word.status = ST_NONE;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			S_HEAD: begin
				desc_re    = 1'b1;
				desc_raddr = AW'({q_q, avail_rd_q[RLOG-1:0] & mask});
			end
			S_WALK: begin
				if (!walk_raw && !walk_long) begin
					desc_re    = 1'b1;
					desc_raddr = desc_rd_q.nxt ? AW'({q_q, nxt_idx})
						: AW'({q_q, head_q[RLOG-1:0] & mask});
				end
			end
			S_EMIT: begin
				res_push                = !res_full;
				res_word.status         = ST_BUF;
				res_word.head_out       = head_q;
				res_word.addr_out       = desc_rd_q.addr;
				res_word.len_out        = desc_rd_q.len;
				res_word.writable_out   = desc_rd_q.wr;
				res_word.position       = 6'(pos_q);
				res_word.readable_count = 7'(readable_q);
				res_word.total_count    = 7'(total_q);
				res_word.last           = emit_last;
				desc_re                 = !res_full && !emit_last;
				desc_raddr              = AW'({q_q, nxt_idx});
			end
			S_ERR: begin
				res_push          = !res_full;
				res_word.status   = err_q;
				res_word.head_out = head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			avail_idx_q <= '{default: '0};
			last_seen_q <= '{default: '0};
			used_idx_q  <= '{default: '0};
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && cmd_pop) begin
				if (cmd.kind == C_PUB) begin
					avail_idx_q[cq] <= cmd.w.avail_index;
				end
				if (cmd.kind == C_RET) begin
					used_idx_q[cq] <= used_idx_q[cq] + 16'd1;
				end
				if (avail_re) begin
					last_seen_q[cq] <= last_seen_q[cq] + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (avail_re) begin
			q_q <= cq;
		end
		if (state_q == S_HEAD) begin
			head_q     <= avail_rd_q;
			total_q    <= CW'(1);
			readable_q <= '0;
			seen_wr_q  <= 1'b0;
		end
		if (state_q == S_WALK) begin
			readable_q <= readable_q + CW'(!desc_rd_q.wr);
			seen_wr_q  <= seen_wr_q | desc_rd_q.wr;
			err_q      <= walk_raw ? ST_RAW : ST_LONG;
			pos_q      <= '0;
			if (desc_rd_q.nxt && !walk_long) begin
				total_q <= total_q + CW'(1);
			end
		end
		if (state_q == S_EMIT && res_push) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_pop && cmd.kind == C_WDESC) begin
			desc_mem[AW'({cq, cmd.w.slot[RLOG-1:0] & mask})] <= '{
				addr: cmd.w.buf_addr, len: cmd.w.buf_len, wr: cmd.w.writable,
				nxt: cmd.w.has_next, next: cmd.w.next_index};
		end
		if (state_q == S_IDLE && cmd_pop && cmd.kind == C_WAVAIL) begin
			avail_mem[AW'({cq, cmd.w.slot[RLOG-1:0] & mask})] <= cmd.w.head_id;
		end
		if (state_q == S_IDLE && cmd_pop && cmd.kind == C_RET) begin
			used_mem[AW'({cq, used_idx_q[cq][RLOG-1:0] & mask})] <=
				{cmd.w.head_id, cmd.w.used_len};
		end
		if (desc_re) begin
			desc_rd_q <= desc_mem[desc_raddr];
		end
		if (avail_re) begin
			avail_rd_q <= avail_mem[avail_raddr];
		end
	end

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> total_q <= n_c)
		else $error("Chain walk exceeded the ring size.");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> CW'(pos_q) < total_q)
		else $error("Emitted position beyond the chain length.");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("Result pushed into a full queue.");
endmodule

// ===== design/virtqueue_descriptor_engine_unit.sv =====
// Top level of the split virtqueue descriptor engine.
//
// Channel   Direction  Handshake          Word
// input     in         push / full       in_word  (in_word_t)
// result    out        pop / empty        out_word (out_word_t)
// config    in         cfg_wr_en          cfg_wr_data (ring_size_log2)
//
// A fetch walks a chain twice, one descriptor memory read per cycle: first a checking walk,
// then an emitting walk that stalls while the result queue is full.
// Reset clears indices and control state; ring memories hold unknown data until written.
// A two-word command queue sets full; the emit walk stalls while the result queue is full.
module virtqueue_descriptor_engine_unit import vqde_pkg::*; #(
	parameter int RING_SIZE = 64,
	parameter int QUEUES    = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  in_word,
	output logic      empty,
	input  logic      pop,
	output out_word_t out_word,
	input  logic      cfg_wr_en,
	input  logic [2:0] cfg_wr_data
);
	logic [2:0] ring_size_log2_q;
	cmd_t       cmd;
	logic       cmd_empty, cmd_pop;
	logic       res_full, res_push;
	out_word_t  res_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_log2_q <= 3'd6;
		end else if (cfg_wr_en) begin
			ring_size_log2_q <= cfg_wr_data;
		end
	end

	vqde_front #(.QUEUES(QUEUES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_word   (in_word),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	vqde_back #(.RING_SIZE(RING_SIZE), .QUEUES(QUEUES)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ring_size_log2 (ring_size_log2_q),
		.cmd            (cmd),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.res_full       (res_full),
		.res_push       (res_push),
		.res_word       (res_word)
	);

	vqde_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(2)) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_word),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (out_word),
		.empty   (empty)
	);
endmodule

// ===== test/vqde_checker.sv =====
`timescale 1ns / 1ps
// Checker for the virtqueue descriptor engine: predicts every result word and compares it.
module vqde_checker import vqde_pkg::*; (
	input  logic       clk,
	input  logic       push,
	input  logic       full,
	input  in_word_t   in_word,
	input  logic       empty,
	input  logic       pop,
	input  out_word_t  out_word,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	output int         errors,
	output int         pending
);

	localparam int RSZ = 64;

	logic [2:0]  size_log2 = 3'd6;
	logic [63:0] d_addr [2*RSZ];
	logic [31:0] d_len [2*RSZ];
	logic        d_wr [2*RSZ];
	logic        d_nxt [2*RSZ];
	logic [15:0] d_next [2*RSZ];
	logic [15:0] avail_ring [2*RSZ];
	logic [15:0] avail_idx [2] = '{16'd0, 16'd0};
	logic [15:0] seen_idx [2] = '{16'd0, 16'd0};
	logic [15:0] used_idx [2] = '{16'd0, 16'd0};
	out_word_t   expected_words [$];
	int          err_count = 0;

	assign errors = err_count;
	assign pending = expected_words.size();

	function automatic int ring_entries();
		int lg;
		lg = (size_log2 < 3'd1) ? 1 : int'(size_log2);
		return ((1 << lg) > RSZ) ? RSZ : (1 << lg);
	endfunction

	function automatic out_word_t word_of(status_t st, logic [15:0] head);
		out_word_t w;
		w = '0;
		w.status = st;
		w.head_out = head;
		w.last = 1'b1;
		return w;
	endfunction

	task automatic predict_item(in_word_t w);
		int n, base, cur, total, readable;
		int chain [RSZ];
		logic seen_wr, failed;
		logic [15:0] head;
		out_word_t r;
		n = ring_entries();
		base = int'(w.queue) * RSZ;
		failed = 1'b0;
		case (w.opcode)
			OP_WDESC: begin
				cur = base + int'(w.slot) % n;
				d_addr[cur] = w.buf_addr;
				d_len[cur] = w.buf_len;
				d_wr[cur] = w.writable;
				d_nxt[cur] = w.has_next;
				d_next[cur] = w.next_index;
			end
			OP_WAVAIL: avail_ring[base + int'(w.slot) % n] = w.head_id;
			OP_PUB: avail_idx[w.queue] = w.avail_index;
			OP_FETCH: begin
				if (seen_idx[w.queue] == avail_idx[w.queue]) begin
					expected_words.push_back(word_of(ST_NONE, 16'd0));
				end else begin
					head = avail_ring[base + int'(seen_idx[w.queue]) % n];
					seen_idx[w.queue] = seen_idx[w.queue] + 16'd1;
					cur = base + int'(head) % n;
					chain[0] = cur;
					total = 1;
					seen_wr = d_wr[cur];
					readable = seen_wr ? 0 : 1;
					while (d_nxt[cur] && !failed) begin
						if (total >= n) begin
							expected_words.push_back(word_of(ST_LONG, head));
							failed = 1'b1;
						end else begin
							cur = base + int'(d_next[cur]) % n;
							if (d_wr[cur]) begin
								seen_wr = 1'b1;
							end else if (seen_wr) begin
								expected_words.push_back(word_of(ST_RAW, head));
								failed = 1'b1;
							end else begin
								readable++;
							end
							chain[total] = cur;
							total++;
						end
					end
					if (!failed) begin
						for (int i = 0; i < total; i++) begin
							r = word_of(ST_BUF, head);
							r.addr_out = d_addr[chain[i]];
							r.len_out = d_len[chain[i]];
							r.writable_out = d_wr[chain[i]];
							r.position = 6'(i);
							r.readable_count = 7'(readable);
							r.total_count = 7'(total);
							r.last = (i + 1 == total);
							expected_words.push_back(r);
						end
					end
				end
			end
			OP_RET: begin
				used_idx[w.queue] = used_idx[w.queue] + 16'd1;
				r = word_of(ST_DONE, w.head_id);
				r.used_index_out = used_idx[w.queue];
				expected_words.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			err_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		out_word_t e;
		if (cfg_wr_en)
			size_log2 = cfg_wr_data;
		if (pop && !empty) begin
			if (expected_words.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result word, expected none, got %h", $time, out_word);
			end else begin
				e = expected_words.pop_front();
				check_field("status", e.status, out_word.status);
				check_field("head_out", e.head_out, out_word.head_out);
				check_field("addr_out", e.addr_out, out_word.addr_out);
				check_field("len_out", e.len_out, out_word.len_out);
				check_field("writable_out", e.writable_out, out_word.writable_out);
				check_field("position", e.position, out_word.position);
				check_field("readable_count", e.readable_count, out_word.readable_count);
				check_field("total_count", e.total_count, out_word.total_count);
				check_field("used_index_out", e.used_index_out, out_word.used_index_out);
				check_field("last", e.last, out_word.last);
			end
		end
		if (push && !full)
			predict_item(in_word);
	end

endmodule

// ===== test/tb_virtqueue_descriptor_engine_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the virtqueue descriptor engine: stimulus, handshake idling and verdict.
module tb_virtqueue_descriptor_engine_unit;
	import vqde_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	in_word_t   in_word = '0;
	logic       empty;
	logic       pop = 1'b0;
	out_word_t  out_word;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_wr_data = 3'd0;
	int         errors;
	int         pending;
	int         send_idle = 24;
	int         recv_idle = 74;
	int         cycles = 0;
	int         ring_n = 64;
	logic [15:0] pub_idx [2] = '{16'd0, 16'd0};

	virtqueue_descriptor_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	vqde_checker u_checker (
		.clk(clk), .push(push), .full(full), .in_word(in_word), .empty(empty),
		.pop(pop), .out_word(out_word), .cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data), .errors(errors), .pending(pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("tb_virtqueue_descriptor_engine_unit: FAIL");
			$finish;
		end
	end

	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_word <= w;
		if (w.opcode == OP_PUB)
			pub_idx[w.queue] = w.avail_index;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_ring_size(logic [2:0] v);
		int lg;
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lg = (v < 3'd1) ? 1 : int'(v);
		ring_n = ((1 << lg) > 64) ? 64 : (1 << lg);
	endtask

	function automatic in_word_t random_word(op_t op, logic q);
		in_word_t w;
		w = $bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		w.opcode = op;
		w.queue = q;
		return w;
	endfunction

	function automatic in_word_t desc_word(logic q, int idx, logic wr, logic nxt, int nidx);
		in_word_t w;
		w = random_word(OP_WDESC, q);
		w.slot = 6'(idx);
		w.writable = wr;
		w.has_next = nxt;
		w.next_index = {10'($urandom_range(1023)), 6'(nidx)};
		return w;
	endfunction

	// Publishes one chain as the next avail entry, fetches it and returns it.
	task automatic run_chain(logic q, int len, logic broken);
		in_word_t w;
		int start, nread;
		logic [15:0] head;
		start = $urandom_range(ring_n - 1);
		nread = $urandom_range(len);
		for (int i = 0; i < len; i++)
			send_word(desc_word(q, (start + i) % ring_n,
				broken ? 1'($urandom) : (i >= nread), i + 1 < len, (start + i + 1) % ring_n));
		head = {10'($urandom_range(1023)), 6'(start)};
		w = random_word(OP_WAVAIL, q);
		w.slot = 6'(pub_idx[q] % ring_n);
		w.head_id = head;
		send_word(w);
		w = random_word(OP_PUB, q);
		w.avail_index = pub_idx[q] + 16'd1;
		send_word(w);
		send_word(random_word(OP_FETCH, q));
		w = random_word(OP_RET, q);
		w.head_id = head;
		send_word(w);
	endtask

	// Publishes come only from whole chains, so a fetch never reaches an unwritten entry.
	task automatic random_phase(int count);
		int pick;
		logic [2:0] op;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(9);
			op = 3'($urandom_range(6));
			if (op >= OP_PUB)
				op = op + 3'd1;
			if (pick < 6)
				run_chain(1'($urandom), $urandom_range(1, (ring_n < 4) ? ring_n : 4), 1'b0);
			else if (pick == 6)
				run_chain(1'($urandom), $urandom_range(1, (ring_n < 8) ? ring_n : 8),
					1'($urandom));
			else if (pick == 7)
				send_word(random_word(OP_FETCH, 1'($urandom)));
			else
				send_word(random_word(op_t'(op), 1'($urandom)));
		end
	endtask

	initial begin
		in_word_t w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(random_word(OP_FETCH, 1'b0));
		send_word(random_word(OP_FETCH, 1'b1));
		send_word(desc_word(1'b0, 5, 1'b0, 1'b1, 5));
		w = random_word(OP_WAVAIL, 1'b0);
		w.slot = 6'd0;
		w.head_id = 16'hFFC5;
		send_word(w);
		w = random_word(OP_PUB, 1'b0);
		w.avail_index = 16'd1;
		send_word(w);
		send_word(random_word(OP_FETCH, 1'b0));
		send_word(desc_word(1'b1, 10, 1'b1, 1'b1, 11));
		send_word(desc_word(1'b1, 11, 1'b0, 1'b0, 0));
		w = random_word(OP_WAVAIL, 1'b1);
		w.slot = 6'd0;
		w.head_id = 16'd10;
		send_word(w);
		w = random_word(OP_PUB, 1'b1);
		w.avail_index = 16'd1;
		send_word(w);
		send_word(random_word(OP_FETCH, 1'b1));
		w = desc_word(1'b0, 20, 1'b1, 1'b0, 0);
		w.buf_addr = '1;
		w.buf_len = '1;
		send_word(w);
		w = random_word(OP_RET, 1'b1);
		w.head_id = 16'hFFFF;
		w.used_len = '1;
		send_word(w);
		send_word(random_word(op_t'(3'd5), 1'b0));
		send_word(random_word(op_t'(3'd7), 1'b1));
		run_chain(1'b0, 3, 1'b0);

		random_phase(4);
		drain();
		random_phase(3);

		set_ring_size(3'd0);
		send_idle = 74;
		recv_idle = 24;
		random_phase(5);

		set_ring_size(3'd7);
		send_idle = 0;
		recv_idle = 0;
		random_phase(4);

		set_ring_size(3'd3);
		random_phase(4);

		drain();
		if (errors == 0)
			$display("tb_virtqueue_descriptor_engine_unit: PASS");
		else
			$display("tb_virtqueue_descriptor_engine_unit: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/vqde_pkg.sv
design/vqde_fifo.sv
design/vqde_front.sv
design/vqde_back.sv
design/virtqueue_descriptor_engine_unit.sv
test/vqde_checker.sv
test/tb_virtqueue_descriptor_engine_unit.sv
